// File: rtl/core/mswse_pkg.sv
// Shared types and constants of the multi-source window state encoder.
// No dependencies; every other file of the block imports this package.
package mswse_pkg;

  localparam int MAX_SOURCES = 2;
  localparam int SAMPLE_BITS = 4;
  localparam int CODE_BITS   = 30;

  localparam int BASE_W      = 5;
  localparam int WIN_W       = 4;
  localparam int LEN_W       = 5;
  localparam int NSRC_W      = 2;
  localparam int SRC_W       = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int FILL_W      = 5;
  localparam int RADIX_W     = 31;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 5;

  localparam logic [FILL_W-1:0]  FILL_MAX   = '1;
  localparam logic [RADIX_W-1:0] RADIX_CAP  = '1;
  localparam logic [RADIX_W-1:0] CODE_LIMIT = RADIX_W'(64'd1 << CODE_BITS);

  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_SOURCES = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_0         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HIST_0         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FUT_0          = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_1         = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HIST_1         = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_FUT_1          = 3'd6;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_SAMPLE = 2'd1;
  localparam logic [1:0] STATUS_BAD_CONFIG = 2'd2;

  typedef logic [MAX_SOURCES-1:0][SAMPLE_BITS-1:0] sample_row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIGIT,
    ST_FOLD,
    ST_TOTAL,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic [NSRC_W-1:0]                  num_src;
    logic [MAX_SOURCES-1:0][BASE_W-1:0] base;
    logic [MAX_SOURCES-1:0][WIN_W-1:0]  hist;
    logic [MAX_SOURCES-1:0][WIN_W-1:0]  fut;
    logic [WIN_W-1:0]                   max_f;
    logic [LEN_W-1:0]                   fill_need;
    logic                               bad;
  } cfg_view_t;

endpackage

// File: rtl/core/mswse_if.sv
// Valid/ready channels of the encoder: sample steps in, codes out.
// Depends on mswse_pkg for field widths.
interface mswse_in_if import mswse_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   first_sample;
  logic [SAMPLE_BITS-1:0] value_0;
  logic [SAMPLE_BITS-1:0] value_1;

  modport source (output valid, first_sample, value_0, value_1, input ready);
  modport sink   (input valid, first_sample, value_0, value_1, output ready);
endinterface

interface mswse_out_if import mswse_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] encoded;
  logic [1:0]           status;

  modport source (output valid, encoded, status, input ready);
  modport sink   (input valid, encoded, status, output ready);
endinterface

// File: rtl/core/mswse_cfg.sv
// Configuration register file of the encoder and the checks derived from it.
// Depends on mswse_pkg.
module mswse_cfg import mswse_pkg::*; #(
  parameter int MAX_WINDOW = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_view_t              view
);

  logic [NSRC_W-1:0]                  active;
  logic [MAX_SOURCES-1:0][BASE_W-1:0] base;
  logic [MAX_SOURCES-1:0][WIN_W-1:0]  hist;
  logic [MAX_SOURCES-1:0][WIN_W-1:0]  fut;

  logic [NSRC_W-1:0] num_src;
  logic [WIN_W-1:0]  max_h;
  logic [WIN_W-1:0]  max_f;
  logic              bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= NSRC_W'(1);
      base   <= {MAX_SOURCES{BASE_W'(2)}};
      hist   <= {MAX_SOURCES{WIN_W'(1)}};
      fut    <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_ACTIVE_SOURCES: active  <= cfg_data[NSRC_W-1:0];
        REG_BASE_0:         base[0] <= cfg_data[BASE_W-1:0];
        REG_HIST_0:         hist[0] <= cfg_data[WIN_W-1:0];
        REG_FUT_0:          fut[0]  <= cfg_data[WIN_W-1:0];
        REG_BASE_1:         base[1] <= cfg_data[BASE_W-1:0];
        REG_HIST_1:         hist[1] <= cfg_data[WIN_W-1:0];
        REG_FUT_1:          fut[1]  <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    num_src = (active > NSRC_W'(MAX_SOURCES)) ? NSRC_W'(MAX_SOURCES) : active;
    max_h   = WIN_W'(1);
    max_f   = '0;
    bad     = (num_src == '0);
    for (int i = 0; i < MAX_SOURCES; i++) begin
      if (NSRC_W'(i) < num_src) begin
        if (base[i] < BASE_W'(2)) bad = 1'b1;
        if (hist[i] > WIN_W'(MAX_WINDOW) || fut[i] > WIN_W'(MAX_WINDOW)) bad = 1'b1;
        if (hist[i] == '0 && fut[i] == '0) bad = 1'b1;
        if (hist[i] > max_h) max_h = hist[i];
        if (fut[i] > max_f) max_f = fut[i];
      end
    end
  end

  always_comb begin
    view.num_src   = num_src;
    view.base      = base;
    view.hist      = hist;
    view.fut       = fut;
    view.max_f     = max_f;
    view.fill_need = LEN_W'(max_h) + LEN_W'(max_f);
    view.bad       = bad;
  end

endmodule

// File: rtl/core/multi_source_window_state_encoder_top.sv
// Top level of the multi-source window state encoder: history memory and sequencer.
// Depends on mswse_pkg, mswse_if (channels) and mswse_cfg (register file).
//
//   channel  | dir | handshake     | word
//   step     | in  | valid / ready | first_sample, value_0, value_1
//   result   | out | valid / ready | encoded, status
//   cfg      | in  | cfg_wen       | cfg_index, cfg_data
//
// A step is accepted only in ST_IDLE, then runs ST_CHECK, per active source ST_DIGIT once
// per window digit, ST_FOLD and ST_TOTAL, then ST_OUT; a bad base, window or source count
// skips to ST_OUT. The history memory, with one read port, yields one window digit per cycle.
// Reset is synchronous; the history needs no clearing, only samples of the current trial
// are read. A code waits in the output register; the sequencer holds in its last step
// only while an earlier code is still untaken.
module multi_source_window_state_encoder_top import mswse_pkg::*; #(
  parameter int MAX_WINDOW = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  mswse_in_if.sink               step,
  mswse_out_if.source            result
);

  localparam int DEPTH = 2 * MAX_WINDOW;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W = PTR_W + 1;

  cfg_view_t view;

  mswse_cfg #(.MAX_WINDOW(MAX_WINDOW)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .view      (view)
  );

  sample_row_t hist_mem [DEPTH];
  sample_row_t mem_q;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] rd_addr;
  logic [IDX_W-1:0] rd_sum;
  logic [LEN_W-1:0] age;
  logic             accept;

  seq_state_t state, state_next;
  logic [PTR_W-1:0]     wr_ptr, wr_ptr_next;
  logic [FILL_W-1:0]    fill, fill_next;
  logic                 bad_seen, bad_seen_next;
  logic                 out_valid, out_valid_next;
  logic [SRC_W-1:0]     src, src_next;
  logic [LEN_W-1:0]     k, k_next;
  logic [CODE_BITS-1:0] st, st_next;
  logic [RADIX_W-1:0]   rad, rad_next;
  logic [RADIX_W-1:0]   total, total_next;
  logic [CODE_BITS-1:0] code, code_next;
  logic                 cfg_bad, cfg_bad_next;
  logic [CODE_BITS-1:0] out_encoded, out_encoded_next;
  logic [1:0]           out_status, out_status_next;

  logic [CODE_BITS+BASE_W-1:0] st_prod;
  logic [RADIX_W+BASE_W-1:0]   rad_prod;
  logic [2*CODE_BITS-1:0]      code_prod;
  logic [2*RADIX_W-1:0]        total_prod;
  logic [LEN_W-1:0]            len_sel;
  logic [PTR_W-1:0]            ptr_base;
  logic [FILL_W-1:0]           fill_base;
  logic                        sample_bad;
  logic                        load;

  assign step.ready      = (state == ST_IDLE);
  assign accept          = step.valid && step.ready;
  assign result.valid    = out_valid;
  assign result.encoded  = out_encoded;
  assign result.status   = out_status;

  assign wr_addr = step.first_sample ? '0 : wr_ptr;

  always_ff @(posedge clk) begin
    if (accept) begin
      hist_mem[wr_addr] <= {step.value_1, step.value_0};
    end
    mem_q <= hist_mem[rd_addr];
  end

  always_comb begin
    age    = LEN_W'(view.max_f) + LEN_W'(view.hist[src_next]) - LEN_W'(1) - k_next;
    rd_sum = IDX_W'(wr_ptr) + IDX_W'(DEPTH - 1) - IDX_W'(age);
    if (rd_sum >= IDX_W'(DEPTH)) begin
      rd_addr = PTR_W'(rd_sum - IDX_W'(DEPTH));
    end else begin
      rd_addr = PTR_W'(rd_sum);
    end
  end

  always_comb begin
    st_prod    = st * view.base[src];
    rad_prod   = rad * view.base[src];
    code_prod  = code * rad[CODE_BITS-1:0];
    total_prod = total * rad;
    len_sel    = LEN_W'(view.hist[src]) + LEN_W'(view.fut[src]);
    ptr_base   = step.first_sample ? '0 : wr_ptr;
    fill_base  = step.first_sample ? '0 : fill;
    sample_bad = 1'b0;
    if (NSRC_W'(0) < view.num_src && BASE_W'(step.value_0) >= view.base[0]) sample_bad = 1'b1;
    if (NSRC_W'(1) < view.num_src && BASE_W'(step.value_1) >= view.base[1]) sample_bad = 1'b1;

    state_next       = state;
    wr_ptr_next      = wr_ptr;
    fill_next        = fill;
    bad_seen_next    = bad_seen;
    src_next         = src;
    k_next           = k;
    st_next          = st;
    rad_next         = rad;
    total_next       = total;
    code_next        = code;
    cfg_bad_next     = cfg_bad;
    out_encoded_next = out_encoded;
    out_status_next  = out_status;
    load             = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          wr_ptr_next   = (ptr_base == PTR_W'(DEPTH - 1)) ? '0 : ptr_base + 1'b1;
          fill_next     = (fill_base == FILL_MAX) ? FILL_MAX : fill_base + 1'b1;
          bad_seen_next = (bad_seen && !step.first_sample) || sample_bad;
          state_next    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        src_next     = '0;
        k_next       = '0;
        st_next      = '0;
        rad_next     = RADIX_W'(1);
        total_next   = RADIX_W'(1);
        code_next    = '0;
        cfg_bad_next = view.bad;
        state_next   = view.bad ? ST_OUT : ST_DIGIT;
      end
      ST_DIGIT: begin
        st_next  = st_prod[CODE_BITS-1:0] + CODE_BITS'(mem_q[src]);
        rad_next = (rad_prod > (RADIX_W+BASE_W)'(RADIX_CAP)) ? RADIX_CAP
                                                            : rad_prod[RADIX_W-1:0];
        if (k + 1'b1 < len_sel) begin
          k_next = k + 1'b1;
        end else begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        code_next  = code_prod[CODE_BITS-1:0] + st;
        state_next = ST_TOTAL;
      end
      ST_TOTAL: begin
        total_next = total_prod[RADIX_W-1:0];
        if (total_prod > (2*RADIX_W)'(CODE_LIMIT)) cfg_bad_next = 1'b1;
        if (NSRC_W'(src) + 1'b1 < view.num_src) begin
          src_next   = src + 1'b1;
          k_next     = '0;
          st_next    = '0;
          rad_next   = RADIX_W'(1);
          state_next = ST_DIGIT;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!cfg_bad && fill < view.fill_need) begin
          state_next = ST_IDLE;
        end else if (!out_valid || result.ready) begin
          load       = 1'b1;
          state_next = ST_IDLE;
          if (cfg_bad) begin
            out_status_next  = STATUS_BAD_CONFIG;
            out_encoded_next = '0;
          end else if (bad_seen) begin
            out_status_next  = STATUS_BAD_SAMPLE;
            out_encoded_next = '0;
          end else begin
            out_status_next  = STATUS_OK;
            out_encoded_next = code;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase

    out_valid_next = (out_valid && !result.ready) || load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wr_ptr    <= '0;
      fill      <= '0;
      bad_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wr_ptr    <= wr_ptr_next;
      fill      <= fill_next;
      bad_seen  <= bad_seen_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    src         <= src_next;
    k           <= k_next;
    st          <= st_next;
    rad         <= rad_next;
    total       <= total_next;
    code        <= code_next;
    cfg_bad     <= cfg_bad_next;
    out_encoded <= out_encoded_next;
    out_status  <= out_status_next;
  end

endmodule

// File: verif/multi_source_window_state_encoder_top_tb.sv
// Self-checking bench for the multi-source window state encoder top level.
// Needs mswse_pkg, the mswse_in_if / mswse_out_if channels and the block itself;
// a directed table runs first, then random trials checked against an in-bench predictor.
module multi_source_window_state_encoder_top_tb;
  import mswse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_MAX       = 8;
  localparam int HIST_DEPTH    = 2 * WIN_MAX;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASE_STEPS   = 135;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [CODE_BITS-1:0] encoded;
    logic [1:0]           status;
  } code_word_t;

  typedef struct packed {
    logic [NSRC_W-1:0]                  active;
    logic [MAX_SOURCES-1:0][BASE_W-1:0] base;
    logic [MAX_SOURCES-1:0][WIN_W-1:0]  hist;
    logic [MAX_SOURCES-1:0][WIN_W-1:0]  fut;
  } settings_t;

  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   fs;
    logic [SAMPLE_BITS-1:0] v0;
    logic [SAMPLE_BITS-1:0] v1;
    bit                     typed;
    code_word_t             word;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_wen;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  mswse_in_if  step_ch ();
  mswse_out_if result_ch ();

  multi_source_window_state_encoder_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step_ch),
    .result    (result_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  settings_t              cur;
  logic [SAMPLE_BITS-1:0] samples [MAX_SOURCES][HIST_DEPTH] = '{default: '0};
  int unsigned            wptr;
  int unsigned            fill;
  bit                     bad_seen;

  code_word_t pending_codes [$];
  plan_row_t  plan [$];
  int         in_idle;
  int         out_idle;
  int         bad_compares;
  int         codes_seen;
  int         steps_sent;
  int         directed_steps;
  int         settings_used;

  function automatic int n_used(settings_t s);
    return (s.active > MAX_SOURCES) ? MAX_SOURCES : int'(s.active);
  endfunction

  function automatic longint unsigned window_span(logic [BASE_W-1:0] b,
                                                  logic [WIN_W-1:0] h, logic [WIN_W-1:0] f);
    longint unsigned q;
    q = 1;
    for (int k = 0; k < h + f; k++) begin
      q = q * b;
      if (q > RADIX_CAP) q = RADIX_CAP;
    end
    return q;
  endfunction

  function automatic bit settings_bad(settings_t s);
    int              ns;
    longint unsigned total;
    ns    = n_used(s);
    total = 1;
    if (ns == 0) return 1'b1;
    for (int i = 0; i < ns; i++) begin
      if (s.base[i] < 2) return 1'b1;
      if (s.hist[i] > WIN_MAX || s.fut[i] > WIN_MAX) return 1'b1;
      if (s.hist[i] == 0 && s.fut[i] == 0) return 1'b1;
      total = total * window_span(s.base[i], s.hist[i], s.fut[i]);
      if (total > (64'd1 << CODE_BITS)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int fill_target(settings_t s, output int max_f);
    int max_h;
    max_h = 1;
    max_f = 0;
    for (int i = 0; i < n_used(s); i++) begin
      if (s.hist[i] > max_h) max_h = s.hist[i];
      if (s.fut[i] > max_f) max_f = s.fut[i];
    end
    return max_h + max_f;
  endfunction

  task automatic encode_step(input logic fs, input logic [SAMPLE_BITS-1:0] v0, v1,
                             output bit emits, output code_word_t word);
    int                     ns;
    int                     max_f;
    int                     need;
    int                     len;
    int                     age;
    int                     idx;
    longint unsigned        code;
    longint unsigned        digits;
    logic [SAMPLE_BITS-1:0] vals [MAX_SOURCES];
    ns      = n_used(cur);
    vals[0] = v0;
    vals[1] = v1;
    emits   = 1'b1;
    word    = '0;
    if (fs) begin
      fill     = 0;
      bad_seen = 1'b0;
      wptr     = 0;
    end
    for (int i = 0; i < MAX_SOURCES; i++) begin
      samples[i][wptr] = vals[i];
      if (i < ns && vals[i] >= cur.base[i]) bad_seen = 1'b1;
    end
    wptr = (wptr + 1) % HIST_DEPTH;
    if (fill < 31) fill++;
    need = fill_target(cur, max_f);
    if (settings_bad(cur)) begin
      word.status = STATUS_BAD_CONFIG;
    end else if (fill < need) begin
      emits = 1'b0;
    end else if (bad_seen) begin
      word.status = STATUS_BAD_SAMPLE;
    end else begin
      code = 0;
      for (int i = 0; i < ns; i++) begin
        len    = cur.hist[i] + cur.fut[i];
        digits = 0;
        for (int k = 0; k < len; k++) begin
          age    = max_f + cur.hist[i] - 1 - k;
          idx    = (wptr + HIST_DEPTH - 1 - age) % HIST_DEPTH;
          digits = digits * cur.base[i] + samples[i][idx];
        end
        code = code * window_span(cur.base[i], cur.hist[i], cur.fut[i]) + digits;
      end
      word.encoded = code[CODE_BITS-1:0];
      word.status  = STATUS_OK;
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_ACTIVE_SOURCES: cur.active  = data[NSRC_W-1:0];
      REG_BASE_0:         cur.base[0] = data[BASE_W-1:0];
      REG_HIST_0:         cur.hist[0] = data[WIN_W-1:0];
      REG_FUT_0:          cur.fut[0]  = data[WIN_W-1:0];
      REG_BASE_1:         cur.base[1] = data[BASE_W-1:0];
      REG_HIST_1:         cur.hist[1] = data[WIN_W-1:0];
      REG_FUT_1:          cur.fut[1]  = data[WIN_W-1:0];
      default: ;
    endcase
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid, wait for every code, then let the sequencer run dry
  task automatic settle();
    step_ch.valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_step(input logic fs, input logic [SAMPLE_BITS-1:0] v0, v1,
                           input bit typed, input code_word_t typed_word);
    bit         emits;
    code_word_t word;
    while ($urandom_range(99) < in_idle) begin
      step_ch.valid <= 1'b0;
      @(posedge clk);
    end
    step_ch.valid        <= 1'b1;
    step_ch.first_sample <= fs;
    step_ch.value_0      <= v0;
    step_ch.value_1      <= v1;
    @(posedge clk);
    while (!step_ch.ready) @(posedge clk);
    steps_sent++;
    encode_step(fs, v0, v1, emits, word);
    if (typed) pending_codes.push_back(typed_word);
    else if (emits) pending_codes.push_back(word);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(int src, bit spoil);
    int b;
    b = cur.base[src];
    if (src >= n_used(cur) || b < 2) return SAMPLE_BITS'($urandom);
    if (spoil) return (b <= 15) ? SAMPLE_BITS'($urandom_range(15, b)) : SAMPLE_BITS'($urandom);
    return (b >= 16) ? SAMPLE_BITS'($urandom) : SAMPLE_BITS'($urandom_range(b - 1));
  endfunction

  task automatic choose_settings(input bit good);
    settings_t s;
    int        tries;
    tries = 0;
    do begin
      if (good) begin
        s.active = ($urandom_range(99) < 10) ? 2'd3 : NSRC_W'($urandom_range(2, 1));
        for (int i = 0; i < MAX_SOURCES; i++) begin
          s.base[i] = ($urandom_range(99) < 30) ? 5'd16 : BASE_W'($urandom_range(15, 2));
          if ($urandom_range(99) < 85) begin
            s.hist[i] = WIN_W'($urandom_range(3));
            s.fut[i]  = WIN_W'($urandom_range(3));
          end else begin
            s.hist[i] = WIN_W'($urandom_range(WIN_MAX));
            s.fut[i]  = WIN_W'($urandom_range(WIN_MAX));
          end
          if (s.hist[i] == 0 && s.fut[i] == 0) s.hist[i] = 1;
        end
      end else begin
        s = settings_t'($urandom);
      end
      tries++;
    end while (good && settings_bad(s) && tries < 30);
    if (good && settings_bad(s)) begin
      s.active  = 2'd1;
      s.base[0] = 5'd16;
      s.hist[0] = 4'd1;
      s.fut[0]  = 4'd0;
    end
    settings_used++;
    write_reg(REG_ACTIVE_SOURCES, {3'($urandom), s.active});
    write_reg(REG_BASE_0, s.base[0]);
    write_reg(REG_HIST_0, {1'($urandom), s.hist[0]});
    write_reg(REG_FUT_0, {1'($urandom), s.fut[0]});
    write_reg(REG_BASE_1, s.base[1]);
    write_reg(REG_HIST_1, {1'($urandom), s.hist[1]});
    write_reg(REG_FUT_1, {1'($urandom), s.fut[1]});
    if ($urandom_range(99) < 20) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
  endtask

  task automatic run_trial();
    int max_f;
    int need;
    int steps;
    int spoil_at;
    bit carry_on;
    need     = fill_target(cur, max_f);
    steps    = ($urandom_range(99) < 10) ? $urandom_range(need, 1) : need + $urandom_range(8);
    spoil_at = ($urandom_range(99) < 8) ? $urandom_range(steps - 1) : -1;
    carry_on = ($urandom_range(99) < 15);
    for (int n = 0; n < steps; n++) begin
      if ($urandom_range(99) < 4)
        send_step(1'($urandom_range(1)), SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                  1'b0, '0);
      else
        send_step(n == 0 && !carry_on, pick_sample(0, n == spoil_at),
                  pick_sample(1, n == spoil_at), 1'b0, '0);
    end
  endtask

  function automatic plan_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r        = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic plan_row_t step_row(logic fs, logic [SAMPLE_BITS-1:0] v0, v1, bit typed,
                                         logic [CODE_BITS-1:0] enc, logic [1:0] st);
    plan_row_t r;
    r              = '{default: '0};
    r.fs           = fs;
    r.v0           = v0;
    r.v1           = v1;
    r.typed        = typed;
    r.word.encoded = enc;
    r.word.status  = st;
    return r;
  endfunction

  always @(posedge clk) result_ch.ready <= ($urandom_range(99) >= out_idle);

  always @(posedge clk) begin : result_check
    code_word_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      codes_seen++;
      if (pending_codes.size() == 0) begin
        bad_compares++;
        if (bad_compares <= 10)
          $display("code %0d arrived with none pending: encoded %0d status %0d",
                   codes_seen, result_ch.encoded, result_ch.status);
      end else begin
        want = pending_codes.pop_front();
        if (result_ch.encoded !== want.encoded || result_ch.status !== want.status) begin
          bad_compares++;
          if (bad_compares <= 10)
            $display("code %0d: wanted encoded %0d status %0d, got encoded %0d status %0d",
                     codes_seen, want.encoded, want.status, result_ch.encoded, result_ch.status);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    bit writing;
    int phase_start;
    rst                  <= 1'b1;
    cfg_wen              <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    step_ch.valid        <= 1'b0;
    step_ch.first_sample <= 1'b0;
    step_ch.value_0      <= '0;
    step_ch.value_1      <= '0;
    cur.active = 2'd1;
    cur.base   = {5'd2, 5'd2};
    cur.hist   = {4'd1, 4'd1};
    cur.fut    = '0;
    wptr       = 0;
    fill       = 0;
    bad_seen   = 1'b0;
    in_idle    = 30;
    out_idle   = 30;

    plan.push_back(step_row(1, 0, 0, 1, 0, STATUS_OK));
    plan.push_back(step_row(0, 1, 15, 1, 1, STATUS_OK));
    plan.push_back(step_row(0, 15, 0, 1, 0, STATUS_BAD_SAMPLE));
    plan.push_back(step_row(0, 0, 0, 1, 0, STATUS_BAD_SAMPLE));
    plan.push_back(step_row(1, 1, 0, 1, 1, STATUS_OK));
    plan.push_back(cfg_row(REG_ACTIVE_SOURCES, 5'd0));
    plan.push_back(step_row(0, 3, 3, 1, 0, STATUS_BAD_CONFIG));
    plan.push_back(cfg_row(REG_ACTIVE_SOURCES, 5'd3));
    plan.push_back(step_row(1, 1, 1, 1, 3, STATUS_OK));
    plan.push_back(step_row(0, 0, 1, 1, 1, STATUS_OK));
    plan.push_back(cfg_row(REG_BASE_0, 5'd1));
    plan.push_back(step_row(0, 1, 0, 1, 0, STATUS_BAD_CONFIG));
    plan.push_back(cfg_row(REG_BASE_0, 5'd31));
    plan.push_back(cfg_row(REG_HIST_0, 5'd15));
    plan.push_back(step_row(0, 0, 0, 1, 0, STATUS_BAD_CONFIG));
    plan.push_back(cfg_row(REG_HIST_0, 5'd0));
    plan.push_back(step_row(0, 0, 0, 1, 0, STATUS_BAD_CONFIG));
    plan.push_back(cfg_row(REG_HIST_0, 5'd8));
    plan.push_back(cfg_row(REG_FUT_0, 5'd8));
    plan.push_back(step_row(0, 0, 0, 1, 0, STATUS_BAD_CONFIG));
    plan.push_back(cfg_row(REG_UNUSED, 5'd31));
    plan.push_back(cfg_row(REG_BASE_0, 5'd16));
    plan.push_back(cfg_row(REG_HIST_0, 5'd1));
    plan.push_back(cfg_row(REG_FUT_0, 5'd6));
    plan.push_back(cfg_row(REG_BASE_1, 5'd4));
    plan.push_back(cfg_row(REG_HIST_1, 5'd1));
    plan.push_back(cfg_row(REG_FUT_1, 5'd0));
    plan.push_back(step_row(1, 15, 3, 0, 0, STATUS_OK));
    repeat (5) plan.push_back(step_row(0, 15, 3, 0, 0, STATUS_OK));
    plan.push_back(step_row(0, 15, 3, 1, 30'h3FFF_FFFF, STATUS_OK));
    plan.push_back(step_row(0, 0, 0, 0, 0, STATUS_OK));
    plan.push_back(step_row(0, 7, 2, 0, 0, STATUS_OK));
    plan.push_back(step_row(1, 8, 1, 0, 0, STATUS_OK));
    plan.push_back(step_row(0, 0, 3, 0, 0, STATUS_OK));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    writing = 1'b1;
    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        if (!writing) settle();
        writing = 1'b1;
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        writing = 1'b0;
        send_step(plan[r].fs, plan[r].v0, plan[r].v1, plan[r].typed, plan[r].word);
      end
    end
    directed_steps = steps_sent;
    settings_used  = 1;

    for (int phase = 0; phase < 3; phase++) begin
      in_idle     = (phase == 0) ? 22 : (phase == 1) ? 88 : 0;
      out_idle    = (phase == 0) ? 88 : (phase == 1) ? 22 : 0;
      phase_start = steps_sent;
      while (steps_sent - phase_start < PHASE_STEPS) begin
        settle();
        choose_settings($urandom_range(99) < 85);
        repeat ($urandom_range(3, 1)) run_trial();
      end
    end

    settle();
    $display("Run covered %0d steps (%0d from the directed table) over %0d register settings,",
             steps_sent, directed_steps, settings_used);
    $display("with %0d codes compared across three idling patterns.", codes_seen);
    if (bad_compares == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
